### hw/rtl/krk_pkg.sv
package krk_pkg;

    // vertex and weight widths are fixed by the beat fields
    localparam int NUM_VERTICES  = 64;
    localparam int VTX_BITS      = 6;
    localparam int WEIGHT_BITS   = 16;
    localparam int RANK_BITS     = 3;
    localparam int MAX_RESULTS   = NUM_VERTICES - 1;
    localparam int DEF_MAX_EDGES = 256;
    localparam int QUEUE_DEPTH   = 2;

    typedef logic [VTX_BITS-1:0]           vtx_t;
    typedef logic signed [WEIGHT_BITS-1:0] wgt_t;
    typedef logic [RANK_BITS-1:0]          rank_t;

    // classified edge beat handed from front to back
    typedef struct packed {
        vtx_t u;
        vtx_t v;
        wgt_t w;
        logic final_edge;
        logic in_range;
    } q_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIND_U,
        ST_CHK_U,
        ST_FIND_V,
        ST_CHK_V,
        ST_JOIN_A,
        ST_JOIN_B,
        ST_EMIT,
        ST_FLUSH
    } back_state_t;

endpackage

### hw/rtl/edge_in_if.sv
interface edge_in_if;
    import krk_pkg::*;

    logic valid;
    logic ready;
    vtx_t end_u;
    vtx_t end_v;
    wgt_t edge_weight;
    logic final_edge;

    modport source (output valid, end_u, end_v, edge_weight, final_edge, input ready);
    modport sink   (input valid, end_u, end_v, edge_weight, final_edge, output ready);
endinterface

### hw/rtl/tree_out_if.sv
interface tree_out_if;
    import krk_pkg::*;

    logic valid;
    logic ready;
    vtx_t tree_u;
    vtx_t tree_v;
    wgt_t tree_weight;
    logic last_of_run;
    logic forest_empty;
    logic edges_dropped;

    modport source (output valid, tree_u, tree_v, tree_weight, last_of_run, forest_empty,
                    edges_dropped, input ready);
    modport sink   (input valid, tree_u, tree_v, tree_weight, last_of_run, forest_empty,
                    edges_dropped, output ready);
endinterface

### hw/rtl/krk_front.sv
module krk_front
    import krk_pkg::*;
(
    edge_in_if.sink edge_in,
    input  logic     q_full,
    output logic     q_push,
    output q_entry_t q_data
);

    // take a beat whenever the queue has room
    assign edge_in.ready = !q_full;
    assign q_push        = edge_in.valid && !q_full;

    // classify: edges with an end outside the vertex range are not stored
    always_comb
    begin
        q_data.u          = edge_in.end_u;
        q_data.v          = edge_in.end_v;
        q_data.w          = edge_in.edge_weight;
        q_data.final_edge = edge_in.final_edge;
        q_data.in_range   = ({1'b0, edge_in.end_u} < (VTX_BITS+1)'(NUM_VERTICES)) &&
                            ({1'b0, edge_in.end_v} < (VTX_BITS+1)'(NUM_VERTICES));
    end

endmodule

### hw/rtl/krk_fifo.sv
module krk_fifo
    import krk_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output q_entry_t pop_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    q_entry_t        slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/krk_back.sv
module krk_back
    import krk_pkg::*;
#(
    parameter int MAX_EDGES = DEF_MAX_EDGES
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    input  q_entry_t q_data,
    output logic     q_pop,
    tree_out_if.source tree_out
);

    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int EB = 2 * VTX_BITS + WEIGHT_BITS;
    localparam int UB = RANK_BITS + VTX_BITS;
    localparam int NB = $clog2(MAX_RESULTS + 1);

    back_state_t state_reg, state_next;

    // edge store
    logic [EB-1:0] emem [MAX_EDGES];
    logic [EB-1:0] em_q;
    logic          em_we;
    logic [AW-1:0] em_wa;
    logic [AW-1:0] em_ra;

    // union-find store: {rank, parent}, with a valid bit per vertex
    logic [UB-1:0] umem [NUM_VERTICES];
    logic          uvalid_reg [NUM_VERTICES];
    logic [UB-1:0] um_q;
    logic          um_vq_reg;
    vtx_t          um_aq_reg;
    logic          um_we;
    vtx_t          um_wa;
    logic [UB-1:0] um_wd;
    vtx_t          um_ra;
    logic          um_clr;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic          have_last_reg, have_last_next;
    wgt_t          last_w_reg, last_w_next;
    logic [AW-1:0] last_idx_reg, last_idx_next;
    logic          best_ok_reg, best_ok_next;
    wgt_t          best_w_reg, best_w_next;
    logic [AW-1:0] best_idx_reg, best_idx_next;
    vtx_t          best_u_reg, best_u_next;
    vtx_t          best_v_reg, best_v_next;
    vtx_t          sel_u_reg, sel_u_next;
    vtx_t          sel_v_reg, sel_v_next;
    wgt_t          sel_w_reg, sel_w_next;
    vtx_t          ru_reg, ru_next;
    rank_t         rku_reg, rku_next;
    vtx_t          rv_reg, rv_next;
    rank_t         rkv_reg, rkv_next;
    logic [NB-1:0] n_reg, n_next;
    logic          held_ok_reg, held_ok_next;
    vtx_t          held_u_reg, held_u_next;
    vtx_t          held_v_reg, held_v_next;
    wgt_t          held_w_reg, held_w_next;

    logic          out_valid_reg;
    vtx_t          out_u_reg;
    vtx_t          out_v_reg;
    wgt_t          out_w_reg;
    logic          out_last_reg;
    logic          out_empty_reg;
    logic          out_drop_reg;
    logic          out_free;
    logic          push;
    vtx_t          push_u;
    vtx_t          push_v;
    wgt_t          push_w;
    logic          push_last;
    logic          push_empty;

    vtx_t          cand_u;
    vtx_t          cand_v;
    wgt_t          cand_w;
    vtx_t          uf_par;
    rank_t         uf_rank;

    assign cand_u  = em_q[EB-1 -: VTX_BITS];
    assign cand_v  = em_q[WEIGHT_BITS +: VTX_BITS];
    assign cand_w  = em_q[WEIGHT_BITS-1:0];
    assign uf_par  = um_vq_reg ? um_q[VTX_BITS-1:0] : um_aq_reg;
    assign uf_rank = um_vq_reg ? um_q[UB-1 -: RANK_BITS] : '0;
    assign out_free = !out_valid_reg || tree_out.ready;

    // edge store ports
    always_ff @(posedge clk)
    begin
        if (em_we)
        begin
            emem[em_wa] <= {q_data.u, q_data.v, q_data.w};
        end
        em_q <= emem[em_ra];
    end

    // union-find store ports
    always_ff @(posedge clk)
    begin
        if (um_we)
        begin
            umem[um_wa] <= um_wd;
        end
        um_q      <= umem[um_ra];
        um_aq_reg <= um_ra;
    end

    // per-vertex valid bits, read alongside the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_VERTICES; i++)
            begin
                uvalid_reg[i] <= 1'b0;
            end
            um_vq_reg <= 1'b0;
        end
        else
        begin
            um_vq_reg <= uvalid_reg[um_ra] && !(um_we && um_wa == um_ra) ? 1'b1 :
                         (um_we && um_wa == um_ra) ? uvalid_reg[um_ra] : 1'b0;
            if (um_clr)
            begin
                for (int i = 0; i < NUM_VERTICES; i++)
                begin
                    uvalid_reg[i] <= 1'b0;
                end
            end
            else if (um_we)
            begin
                uvalid_reg[um_wa] <= 1'b1;
            end
        end
    end

    // sequencer: load, select next edge by scan, find roots, join, emit, flush
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        scan_next      = scan_reg;
        rd_pend_next   = 1'b0;
        rd_idx_next    = rd_idx_reg;
        have_last_next = have_last_reg;
        last_w_next    = last_w_reg;
        last_idx_next  = last_idx_reg;
        best_ok_next   = best_ok_reg;
        best_w_next    = best_w_reg;
        best_idx_next  = best_idx_reg;
        best_u_next    = best_u_reg;
        best_v_next    = best_v_reg;
        sel_u_next     = sel_u_reg;
        sel_v_next     = sel_v_reg;
        sel_w_next     = sel_w_reg;
        ru_next        = ru_reg;
        rku_next       = rku_reg;
        rv_next        = rv_reg;
        rkv_next       = rkv_reg;
        n_next         = n_reg;
        held_ok_next   = held_ok_reg;
        held_u_next    = held_u_reg;
        held_v_next    = held_v_reg;
        held_w_next    = held_w_reg;
        q_pop          = 1'b0;
        em_we          = 1'b0;
        em_wa          = cnt_reg[AW-1:0];
        em_ra          = scan_reg[AW-1:0];
        um_we          = 1'b0;
        um_wa          = ru_reg;
        um_wd          = '0;
        um_ra          = '0;
        um_clr         = 1'b0;
        push           = 1'b0;
        push_u         = held_u_reg;
        push_v         = held_v_reg;
        push_w         = held_w_reg;
        push_last      = 1'b0;
        push_empty     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                q_pop = q_valid;
                if (q_valid)
                begin
                    if (q_data.in_range)
                    begin
                        if (cnt_reg < CW'(MAX_EDGES))
                        begin
                            em_we    = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (q_data.final_edge)
                    begin
                        scan_next      = '0;
                        best_ok_next   = 1'b0;
                        have_last_next = 1'b0;
                        n_next         = '0;
                        held_ok_next   = 1'b0;
                        state_next     = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // check the beat read last cycle against the running pick
                if (rd_pend_reg)
                begin
                    if ((!have_last_reg || cand_w > last_w_reg ||
                         (cand_w == last_w_reg && rd_idx_reg > last_idx_reg)) &&
                        (!best_ok_reg || cand_w < best_w_reg))
                    begin
                        best_ok_next  = 1'b1;
                        best_w_next   = cand_w;
                        best_idx_next = rd_idx_reg;
                        best_u_next   = cand_u;
                        best_v_next   = cand_v;
                    end
                end
                if (scan_reg < cnt_reg)
                begin
                    rd_pend_next = 1'b1;
                    rd_idx_next  = scan_reg[AW-1:0];
                    scan_next    = scan_reg + 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    if (best_ok_reg)
                    begin
                        have_last_next = 1'b1;
                        last_w_next    = best_w_reg;
                        last_idx_next  = best_idx_reg;
                        sel_u_next     = best_u_reg;
                        sel_v_next     = best_v_reg;
                        sel_w_next     = best_w_reg;
                        state_next     = ST_FIND_U;
                    end
                    else
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FIND_U:
            begin
                um_ra      = sel_u_reg;
                state_next = ST_CHK_U;
            end

            ST_CHK_U:
            begin
                if (uf_par == um_aq_reg)
                begin
                    ru_next    = um_aq_reg;
                    rku_next   = uf_rank;
                    state_next = ST_FIND_V;
                end
                else
                begin
                    um_ra = uf_par;
                end
            end

            ST_FIND_V:
            begin
                um_ra      = sel_v_reg;
                state_next = ST_CHK_V;
            end

            ST_CHK_V:
            begin
                if (uf_par == um_aq_reg)
                begin
                    rv_next  = um_aq_reg;
                    rkv_next = uf_rank;
                    if (um_aq_reg != ru_reg && n_reg < NB'(MAX_RESULTS))
                    begin
                        state_next = ST_JOIN_A;
                    end
                    else
                    begin
                        scan_next    = '0;
                        best_ok_next = 1'b0;
                        state_next   = ST_SCAN;
                    end
                end
                else
                begin
                    um_ra = uf_par;
                end
            end

            ST_JOIN_A:
            begin
                um_we = 1'b1;
                if (rku_reg > rkv_reg)
                begin
                    um_wa      = rv_reg;
                    um_wd      = {rkv_reg, ru_reg};
                    state_next = ST_EMIT;
                end
                else
                begin
                    um_wa      = ru_reg;
                    um_wd      = {rku_reg, rv_reg};
                    state_next = (rku_reg == rkv_reg) ? ST_JOIN_B : ST_EMIT;
                end
            end

            ST_JOIN_B:
            begin
                um_we      = 1'b1;
                um_wa      = rv_reg;
                um_wd      = {rank_t'(rkv_reg + 1'b1), rv_reg};
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                // the held edge goes out once a later one is known
                if (!held_ok_reg || out_free)
                begin
                    push         = held_ok_reg;
                    held_ok_next = 1'b1;
                    held_u_next  = sel_u_reg;
                    held_v_next  = sel_v_reg;
                    held_w_next  = sel_w_reg;
                    n_next       = n_reg + 1'b1;
                    scan_next    = '0;
                    best_ok_next = 1'b0;
                    state_next   = ST_SCAN;
                end
            end

            ST_FLUSH:
            begin
                if (out_free)
                begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    if (!held_ok_reg)
                    begin
                        push_u     = '0;
                        push_v     = '0;
                        push_w     = '0;
                        push_empty = 1'b1;
                    end
                    um_clr       = 1'b1;
                    cnt_next     = '0;
                    ovf_next     = 1'b0;
                    held_ok_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            rd_pend_reg   <= 1'b0;
            have_last_reg <= 1'b0;
            best_ok_reg   <= 1'b0;
            held_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            rd_pend_reg   <= rd_pend_next;
            have_last_reg <= have_last_next;
            best_ok_reg   <= best_ok_next;
            held_ok_reg   <= held_ok_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (tree_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        rd_idx_reg   <= rd_idx_next;
        last_w_reg   <= last_w_next;
        last_idx_reg <= last_idx_next;
        best_w_reg   <= best_w_next;
        best_idx_reg <= best_idx_next;
        best_u_reg   <= best_u_next;
        best_v_reg   <= best_v_next;
        sel_u_reg    <= sel_u_next;
        sel_v_reg    <= sel_v_next;
        sel_w_reg    <= sel_w_next;
        ru_reg       <= ru_next;
        rku_reg      <= rku_next;
        rv_reg       <= rv_next;
        rkv_reg      <= rkv_next;
        n_reg        <= n_next;
        held_u_reg   <= held_u_next;
        held_v_reg   <= held_v_next;
        held_w_reg   <= held_w_next;
        if (push)
        begin
            out_u_reg     <= push_u;
            out_v_reg     <= push_v;
            out_w_reg     <= push_w;
            out_last_reg  <= push_last;
            out_empty_reg <= push_empty;
            out_drop_reg  <= ovf_reg;
        end
    end

    assign tree_out.valid         = out_valid_reg;
    assign tree_out.tree_u        = out_u_reg;
    assign tree_out.tree_v        = out_v_reg;
    assign tree_out.tree_weight   = out_w_reg;
    assign tree_out.last_of_run   = out_last_reg;
    assign tree_out.forest_empty  = out_empty_reg;
    assign tree_out.edges_dropped = out_drop_reg;

endmodule

### hw/rtl/kruskal_min_spanning_forest_unit.sv
// channel    dir  beat                                        handshake
// edge_in    in   end_u, end_v, edge_weight, final_edge       valid/ready
// tree_out   out  tree_u, tree_v, tree_weight, last_of_run,   valid/ready
//                 forest_empty, edges_dropped
//
// an edge beat without the final flag passes through the queue into the edge store when the store has room
// a run over n stored edges rescans the whole store for each of up to n selections,
// walks the parent chain from each end of a selected edge to its root and joins the
// two roots when they differ
// the edge store has a single read port, so each scan reads the stored edges one by one
// reset clears counts and the union-find valid bits at once; no clearing pass
// a stalled output holds the back end; the front keeps taking beats into the queue until it is full
module kruskal_min_spanning_forest_unit
    import krk_pkg::*;
#(
    parameter int MAX_EDGES = DEF_MAX_EDGES
)
(
    input logic clk,
    input logic rst_n,
    edge_in_if.sink    edge_in,
    tree_out_if.source tree_out
);

    logic     q_full;
    logic     q_push;
    q_entry_t q_in;
    logic     q_pop;
    logic     q_valid;
    q_entry_t q_out;

    krk_front u_front (
        .edge_in (edge_in),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    krk_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    krk_back #(
        .MAX_EDGES (MAX_EDGES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .tree_out (tree_out)
    );

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import krk_pkg::*;

    // one forest edge as it should leave the block
    typedef struct {
        vtx_t u;
        vtx_t v;
        wgt_t w;
        logic last;
        logic empty;
        logic dropped;
    } tree_beat_t;

    class forest_scoreboard;
        vtx_t         graph_u[DEF_MAX_EDGES];
        vtx_t         graph_v[DEF_MAX_EDGES];
        wgt_t         graph_w[DEF_MAX_EDGES];
        int           graph_len;
        bit           graph_overflow;
        tree_beat_t   forest_q[$];
        int           mismatches;

        function new();
            graph_len = 0;
            graph_overflow = 0;
            mismatches = 0;
        endfunction

        function automatic vtx_t root_of(ref vtx_t up[NUM_VERTICES], input vtx_t x);
            int steps;
            steps = 0;
            while (up[x] != x && steps < NUM_VERTICES)
            begin
                x = up[x];
                steps++;
            end
            return x;
        endfunction

        // build the expected forest listing of the graph held so far
        function void build_forest();
            int          order[$];
            vtx_t        up[NUM_VERTICES];
            int unsigned rk[NUM_VERTICES];
            int          j;
            int          n;
            vtx_t        ru;
            vtx_t        rv;
            tree_beat_t  b;
            for (int i = 0; i < NUM_VERTICES; i++)
            begin
                up[i] = vtx_t'(i);
                rk[i] = 0;
            end
            // stable insertion by signed weight
            for (int i = 0; i < graph_len; i++)
            begin
                j = order.size();
                while (j > 0 && graph_w[order[j-1]] > graph_w[i])
                    j--;
                order.insert(j, i);
            end
            n = 0;
            foreach (order[k])
            begin
                ru = root_of(up, graph_u[order[k]]);
                rv = root_of(up, graph_v[order[k]]);
                if (ru != rv && n < MAX_RESULTS)
                begin
                    if (rk[ru] > rk[rv])
                        up[rv] = ru;
                    else
                    begin
                        up[ru] = rv;
                        if (rk[ru] == rk[rv])
                            rk[rv]++;
                    end
                    b.u = graph_u[order[k]];
                    b.v = graph_v[order[k]];
                    b.w = graph_w[order[k]];
                    b.last = 0;
                    b.empty = 0;
                    b.dropped = graph_overflow;
                    forest_q.insert(forest_q.size(), b);
                    n++;
                end
            end
            if (n == 0)
            begin
                b.u = '0;
                b.v = '0;
                b.w = '0;
                b.last = 1;
                b.empty = 1;
                b.dropped = graph_overflow;
                forest_q.insert(forest_q.size(), b);
            end
            else
                forest_q[forest_q.size()-1].last = 1;
            graph_len = 0;
            graph_overflow = 0;
        endfunction

        // an accepted edge beat
        function void note_edge(vtx_t u, vtx_t v, wgt_t w, logic fin);
            if (graph_len < DEF_MAX_EDGES)
            begin
                graph_u[graph_len] = u;
                graph_v[graph_len] = v;
                graph_w[graph_len] = w;
                graph_len++;
            end
            else
                graph_overflow = 1;
            if (fin)
                build_forest();
        endfunction

        // an accepted forest beat
        function void check_tree(tree_beat_t got);
            tree_beat_t exp_b;
            if (forest_q.size() == 0)
            begin
                $error("forest beat with nothing expected");
                mismatches++;
                return;
            end
            exp_b = forest_q.pop_front();
            if (got.u !== exp_b.u)
            begin
                $error("tree_u expected %0d got %0d", exp_b.u, got.u);
                mismatches++;
            end
            if (got.v !== exp_b.v)
            begin
                $error("tree_v expected %0d got %0d", exp_b.v, got.v);
                mismatches++;
            end
            if (got.w !== exp_b.w)
            begin
                $error("tree_weight expected %0d got %0d", exp_b.w, got.w);
                mismatches++;
            end
            if (got.last !== exp_b.last)
            begin
                $error("last_of_run expected %0b got %0b", exp_b.last, got.last);
                mismatches++;
            end
            if (got.empty !== exp_b.empty)
            begin
                $error("forest_empty expected %0b got %0b", exp_b.empty, got.empty);
                mismatches++;
            end
            if (got.dropped !== exp_b.dropped)
            begin
                $error("edges_dropped expected %0b got %0b", exp_b.dropped, got.dropped);
                mismatches++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 400000;

    logic clk;
    logic rst_n;

    edge_in_if  edge_in ();
    tree_out_if tree_out ();

    kruskal_min_spanning_forest_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .edge_in  (edge_in),
        .tree_out (tree_out)
    );

    forest_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold;
    int quiet_cycles;
    int edges_sent;

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver ready with random stalls and one long hold-off
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            tree_out.ready <= 1'b0;
        end
        else
            tree_out.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // check accepted forest beats
    always @(posedge clk)
    begin
        tree_beat_t got;
        if (rst_n && tree_out.valid && tree_out.ready)
        begin
            got.u = tree_out.tree_u;
            got.v = tree_out.tree_v;
            got.w = tree_out.tree_weight;
            got.last = tree_out.last_of_run;
            got.empty = tree_out.forest_empty;
            got.dropped = tree_out.edges_dropped;
            sb.check_tree(got);
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((edge_in.valid && edge_in.ready) || (tree_out.valid && tree_out.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_edge(vtx_t u, vtx_t v, wgt_t w, logic fin);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            edge_in.valid <= 1'b0;
            @(posedge clk);
        end
        edge_in.valid <= 1'b1;
        edge_in.end_u <= u;
        edge_in.end_v <= v;
        edge_in.edge_weight <= w;
        edge_in.final_edge <= fin;
        @(posedge clk);
        while (!edge_in.ready)
            @(posedge clk);
        sb.note_edge(u, v, w, fin);
        edges_sent++;
    endtask

    // random graph, mostly small, vertices often crowded to force cycles
    task automatic send_random_graph(int max_len);
        int   len;
        int   vtop;
        bit   narrow_w;
        wgt_t w;
        len = $urandom_range(1, max_len);
        vtop = ($urandom_range(1) == 0) ? $urandom_range(1, 9) : 63;
        narrow_w = $urandom_range(1);
        for (int i = 0; i < len; i++)
        begin
            w = narrow_w ? wgt_t'($signed($urandom_range(8)) - 4) : wgt_t'($urandom);
            send_edge(vtx_t'($urandom_range(vtop)), vtx_t'($urandom_range(vtop)), w,
                      i == len - 1);
        end
    endtask

    // stop offering beats and wait for every expected forest beat
    task automatic wait_forest_done();
        edge_in.valid <= 1'b0;
        while (sb.forest_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int phase_start;
        sb = new();
        tx_idle_pct = 22;
        rx_idle_pct = 78;
        rx_hold = 0;
        quiet_cycles = 0;
        edges_sent = 0;
        edge_in.valid = 1'b0;
        edge_in.end_u = '0;
        edge_in.end_v = '0;
        edge_in.edge_weight = '0;
        edge_in.final_edge = 1'b0;
        tree_out.ready = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // self loop alone gives an empty forest
        send_edge(6'd7, 6'd7, 16'sd5, 1'b1);
        // weight extremes, end vertices, equal weights and a self loop
        send_edge(6'd0, 6'd63, -16'sd32768, 1'b0);
        send_edge(6'd63, 6'd0, 16'sd32767, 1'b0);
        send_edge(6'd1, 6'd2, 16'sd0, 1'b0);
        send_edge(6'd2, 6'd1, 16'sd0, 1'b0);
        send_edge(6'd5, 6'd5, -16'sd1, 1'b0);
        send_edge(6'd2, 6'd63, 16'sd0, 1'b0);
        send_edge(6'd42, 6'd21, 16'sd32767, 1'b1);

        // long receiver hold-off while the next graphs keep coming
        rx_hold = 400;
        send_random_graph(10);
        send_random_graph(10);

        // sender waits out the block
        wait_forest_done();

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 78 : 0;
            rx_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 22 : 0;
            phase_start = edges_sent;
            while (edges_sent - phase_start < 15)
                send_random_graph(($urandom_range(9) == 0) ? 40 : 12);
        end

        // overfull store: dropped edges flagged, run still starts
        for (int i = 0; i < DEF_MAX_EDGES + 3; i++)
            send_edge(vtx_t'($urandom_range(63)), vtx_t'($urandom_range(63)),
                      wgt_t'($urandom), i == DEF_MAX_EDGES + 2);
        // the store empties after a run
        send_random_graph(6);

        wait_forest_done();
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
